FILE: rtl/ihpq_pkg.sv
// ----------------------------------------------------------------------------
// ihpq_pkg
// Shared types and codes for the interval heap dual priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ihpq_pkg;

    localparam logic [1:0] REQ_PUSH    = 2'd0;
    localparam logic [1:0] REQ_POP_MIN = 2'd1;
    localparam logic [1:0] REQ_POP_MAX = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_PU_START,
        S_PU_PAIR,
        S_PU_SIB,
        S_PU_SIBC,
        S_PU_UP,
        S_PU_UPC,
        S_PM_R0,
        S_PM_RL,
        S_PX_SM,
        S_PX_R1,
        S_PX_RL,
        S_SE_TOP,
        S_SE_SIB,
        S_SE_L,
        S_SE_LC,
        S_SE_RC,
        S_SE_END,
        S_SO_TOP,
        S_SO_SIB,
        S_SO_L,
        S_SO_LC,
        S_SO_RC,
        S_SO_END,
        S_WRX,
        S_FIN_R0,
        S_FIN_R1,
        S_FIN_OUT,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/interval_heap_dual_priority_queue.sv
// ----------------------------------------------------------------------------
// interval_heap_dual_priority_queue
// Double-ended priority queue kept as an interval heap in one RAM.
// ----------------------------------------------------------------------------
// Each item pushes a signed value, pops the minimum or pops the maximum, and
// yields one result item with the popped value, a status code, the element
// count and the current minimum and maximum. Even slots form a min-heap, odd
// slots a max-heap. A sequencer walks the heap one slot read at a time
// through a single RAM read port with registered data and one shared
// comparator, so the block takes one item at a time. The cost of a push
// grows with the levels it climbs and that of a pop with the levels it
// descends; the RAM read port sets the pace of each step. A pop on an
// empty queue and a push on a full queue are flagged and change nothing;
// request type three is answered and ignored. The store needs no
// clearing: only slots below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_heap_dual_priority_queue #(
    parameter int CAPACITY   = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_req_type,
    input  wire logic [DATA_WIDTH-1:0]          s_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [DATA_WIDTH-1:0]               m_popped_value,
    output logic [1:0]                          m_status,
    output logic [$clog2(CAPACITY+1)-1:0]       m_count_after,
    output logic [DATA_WIDTH-1:0]               m_min_value,
    output logic [DATA_WIDTH-1:0]               m_max_value
);

    import ihpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int DW = DATA_WIDTH;

    state_t state_reg, state_next;

    logic [1:0]    req_reg, req_next;
    logic [DW-1:0] x_reg, x_next;        // element moving through the heap
    logic [AW-1:0] i_reg, i_next;        // current hole slot
    logic [CW-1:0] n_reg, n_next;        // element count
    logic [AW-1:0] j_reg, j_next;        // best child slot
    logic [DW-1:0] jv_reg, jv_next;      // best child value
    logic [DW-1:0] pop_reg, pop_next;
    logic [1:0]    stat_reg, stat_next;
    logic [DW-1:0] min_reg, min_next;
    logic [DW-1:0] max_reg, max_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic [DW-1:0] cmp_a, cmp_b;
    logic          lt;

    // Index arithmetic, widened so child slots past the end compare cleanly.
    logic [IW-1:0] i_ext, n_ext, par, el, er, ol_raw, or_raw, ol, odr;
    logic [AW-1:0] par_a;
    logic          full, up_more, el_in, er_in, ol_in, or_in;

    assign i_ext   = IW'(i_reg);
    assign n_ext   = IW'(n_reg);
    assign par     = (i_ext + (i_ext & IW'(3)) - IW'(4)) >> 1;
    assign par_a   = par[AW-1:0];
    assign el      = (i_ext << 1) + IW'(2);
    assign er      = (i_ext << 1) + IW'(4);
    assign ol_raw  = (i_ext << 1) + IW'(1);
    assign or_raw  = (i_ext << 1) + IW'(3);
    assign ol      = (ol_raw >= n_ext) ? ol_raw - IW'(1) : ol_raw;
    assign odr     = (or_raw >= n_ext) ? or_raw - IW'(1) : or_raw;
    assign el_in   = el < n_ext;
    assign er_in   = er < n_ext;
    assign ol_in   = ol < n_ext;
    assign or_in   = odr < n_ext;
    assign full    = n_reg == CW'(CAPACITY);
    assign up_more = i_reg[0] ? (i_ext >= IW'(3)) : (i_ext >= IW'(2));

    ihpq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (we),
        .wr_addr (waddr),
        .wr_data (wdata),
        .rd_addr (raddr),
        .rd_data (rdata)
    );

    ihpq_cmp #(
        .WIDTH (DW)
    ) u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (lt)
    );

    // Steer the shared comparator for the current step.
    always_comb begin
        cmp_a = x_reg;
        cmp_b = rdata;
        case (state_reg)
            S_PU_PAIR, S_SE_SIB: begin
                cmp_a = rdata;
                cmp_b = x_reg;
            end
            S_PU_UPC: begin
                cmp_a = i_reg[0] ? rdata : x_reg;
                cmp_b = i_reg[0] ? x_reg : rdata;
            end
            S_SE_LC, S_SE_RC: begin
                cmp_a = rdata;
                cmp_b = jv_reg;
            end
            S_SO_LC, S_SO_RC: begin
                cmp_a = jv_reg;
                cmp_b = rdata;
            end
            default: begin
                cmp_a = x_reg;
                cmp_b = rdata;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (s_valid) state_next = S_DISP;
            S_DISP: begin
                case (req_reg)
                    REQ_PUSH:    state_next = full ? S_FIN_R0 : S_PU_START;
                    REQ_POP_MIN: state_next = (n_reg == '0) ? S_FIN_R0 : S_PM_R0;
                    REQ_POP_MAX: begin
                        if (n_reg == '0) begin
                            state_next = S_FIN_R0;
                        end else if (n_reg <= CW'(2)) begin
                            state_next = S_PX_SM;
                        end else begin
                            state_next = S_PX_R1;
                        end
                    end
                    default:     state_next = S_FIN_R0;
                endcase
            end
            S_PU_START: state_next = (i_ext >= IW'(2) && !i_reg[0]) ? S_PU_PAIR : S_PU_SIB;
            S_PU_PAIR:  state_next = S_PU_SIB;
            S_PU_SIB:   state_next = i_reg[0] ? S_PU_SIBC : S_PU_UP;
            S_PU_SIBC:  state_next = S_PU_UP;
            S_PU_UP:    state_next = up_more ? S_PU_UPC : S_WRX;
            S_PU_UPC:   state_next = lt ? S_PU_UP : S_WRX;
            S_PM_R0:    state_next = S_PM_RL;
            S_PM_RL:    state_next = (n_reg == '0) ? S_FIN_R0 : S_SE_TOP;
            S_PX_SM:    state_next = S_FIN_R0;
            S_PX_R1:    state_next = S_PX_RL;
            S_PX_RL:    state_next = S_SO_TOP;
            S_SE_TOP:   state_next = (i_ext + IW'(1) < n_ext) ? S_SE_SIB : S_SE_L;
            S_SE_SIB:   state_next = S_SE_L;
            S_SE_L:     state_next = el_in ? S_SE_LC : S_SE_END;
            S_SE_LC:    state_next = er_in ? S_SE_RC : S_SE_END;
            S_SE_RC:    state_next = S_SE_END;
            S_SE_END:   state_next = (j_reg == i_reg) ? S_WRX : S_SE_TOP;
            S_SO_TOP:   state_next = S_SO_SIB;
            S_SO_SIB:   state_next = S_SO_L;
            S_SO_L: begin
                if (ol_in) begin
                    state_next = S_SO_LC;
                end else if (or_in) begin
                    state_next = S_SO_RC;
                end else begin
                    state_next = S_SO_END;
                end
            end
            S_SO_LC:    state_next = or_in ? S_SO_RC : S_SO_END;
            S_SO_RC:    state_next = S_SO_END;
            S_SO_END: begin
                if (j_reg == i_reg || !j_reg[0]) begin
                    state_next = S_WRX;
                end else begin
                    state_next = S_SO_TOP;
                end
            end
            S_WRX:      state_next = S_FIN_R0;
            S_FIN_R0:   state_next = S_FIN_R1;
            S_FIN_R1:   state_next = S_FIN_OUT;
            S_FIN_OUT:  state_next = S_OUT;
            S_OUT:      if (m_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM control and result registers.
    always_comb begin
        req_next  = req_reg;
        x_next    = x_reg;
        i_next    = i_reg;
        n_next    = n_reg;
        j_next    = j_reg;
        jv_next   = jv_reg;
        pop_next  = pop_reg;
        stat_next = stat_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        we        = 1'b0;
        waddr     = i_reg;
        wdata     = x_reg;
        raddr     = '0;
        case (state_reg)
            S_IDLE: begin
                // latch the request and clear the popped value and status
                req_next  = s_req_type;
                x_next    = s_value;
                pop_next  = '0;
                stat_next = ST_OK;
            end
            S_DISP: begin
                case (req_reg)
                    REQ_PUSH: begin
                        if (full) begin
                            stat_next = ST_FULL;
                        end else begin
                            i_next = n_reg[AW-1:0];
                            n_next = n_reg + CW'(1);
                        end
                    end
                    REQ_POP_MIN: begin
                        if (n_reg == '0) begin
                            stat_next = ST_EMPTY;
                        end else begin
                            raddr  = '0;
                            i_next = '0;
                            n_next = n_reg - CW'(1);
                        end
                    end
                    REQ_POP_MAX: begin
                        if (n_reg == '0) begin
                            stat_next = ST_EMPTY;
                        end else if (n_reg <= CW'(2)) begin
                            raddr  = AW'(n_reg - CW'(1));
                            n_next = n_reg - CW'(1);
                        end else begin
                            raddr  = AW'(1);
                            i_next = AW'(1);
                            n_next = n_reg - CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PU_START: raddr = par_a ^ AW'(1);
            S_PU_PAIR: begin
                if (lt) begin
                    we     = 1'b1;
                    wdata  = rdata;
                    i_next = par_a ^ AW'(1);
                end
            end
            S_PU_SIB:   raddr = i_reg - AW'(1);
            S_PU_SIBC: begin
                if (lt) begin
                    we     = 1'b1;
                    wdata  = rdata;
                    i_next = i_reg - AW'(1);
                end
            end
            S_PU_UP:    raddr = par_a;
            S_PU_UPC: begin
                if (lt) begin
                    we     = 1'b1;
                    wdata  = rdata;
                    i_next = par_a;
                end
            end
            S_PM_R0: begin
                pop_next = rdata;
                raddr    = n_reg[AW-1:0];
            end
            S_PM_RL:    x_next = rdata;
            S_PX_SM:    pop_next = rdata;
            S_PX_R1: begin
                pop_next = rdata;
                raddr    = n_reg[AW-1:0];
            end
            S_PX_RL:    x_next = rdata;
            // min-heap descent
            S_SE_TOP:   raddr = i_reg + AW'(1);
            S_SE_SIB: begin
                if (lt) begin
                    we     = 1'b1;
                    waddr  = i_reg + AW'(1);
                    wdata  = x_reg;
                    x_next = rdata;
                end
            end
            S_SE_L: begin
                j_next  = i_reg;
                jv_next = x_reg;
                raddr   = el[AW-1:0];
            end
            S_SE_LC: begin
                if (lt) begin
                    j_next  = el[AW-1:0];
                    jv_next = rdata;
                end
                raddr = er[AW-1:0];
            end
            S_SE_RC: begin
                if (lt) begin
                    j_next  = er[AW-1:0];
                    jv_next = rdata;
                end
            end
            S_SE_END: begin
                if (j_reg != i_reg) begin
                    we     = 1'b1;
                    wdata  = jv_reg;
                    i_next = j_reg;
                end
            end
            // max-heap descent
            S_SO_TOP:   raddr = i_reg - AW'(1);
            S_SO_SIB: begin
                if (lt) begin
                    we     = 1'b1;
                    waddr  = i_reg - AW'(1);
                    wdata  = x_reg;
                    x_next = rdata;
                end
            end
            S_SO_L: begin
                j_next  = i_reg;
                jv_next = x_reg;
                raddr   = ol_in ? ol[AW-1:0] : odr[AW-1:0];
            end
            S_SO_LC: begin
                if (lt) begin
                    j_next  = ol[AW-1:0];
                    jv_next = rdata;
                end
                raddr = odr[AW-1:0];
            end
            S_SO_RC: begin
                if (lt) begin
                    j_next  = odr[AW-1:0];
                    jv_next = rdata;
                end
            end
            S_SO_END: begin
                if (j_reg != i_reg) begin
                    we     = 1'b1;
                    wdata  = jv_reg;
                    i_next = j_reg;
                end
            end
            S_WRX:      we = 1'b1;   // drop the moving element into its hole
            S_FIN_R0:   raddr = '0;
            S_FIN_R1: begin
                min_next = rdata;
                raddr    = AW'(1);
            end
            S_FIN_OUT: begin
                if (n_reg == '0) begin
                    min_next = '0;
                    max_next = '0;
                end else if (n_reg == CW'(1)) begin
                    max_next = min_reg;
                end else begin
                    max_next = rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
        req_reg  <= req_next;
        x_reg    <= x_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        jv_reg   <= jv_next;
        pop_reg  <= pop_next;
        stat_reg <= stat_next;
        min_reg  <= min_next;
        max_reg  <= max_next;
    end

    assign s_ready        = state_reg == S_IDLE;
    assign m_valid        = state_reg == S_OUT;
    assign m_popped_value = pop_reg;
    assign m_status       = stat_reg;
    assign m_count_after  = n_reg;
    assign m_min_value    = min_reg;
    assign m_max_value    = max_reg;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result item is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> m_count_after == CW'(CAPACITY))
        else $error("full status with room left");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_count_after == '0) |-> (m_min_value == '0 && m_max_value == '0))
        else $error("empty queue reports nonzero bounds");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> m_count_after == '0)
        else $error("empty status on a non-empty queue");

endmodule

`default_nettype wire

FILE: rtl/ihpq_ram.sv
// ----------------------------------------------------------------------------
// ihpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ihpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/ihpq_cmp.sv
// ----------------------------------------------------------------------------
// ihpq_cmp
// Shared signed less-than unit used by every sift step.
// ----------------------------------------------------------------------------
`default_nettype none

module ihpq_cmp #(
    parameter int WIDTH = 32
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    output logic                  lt
);

    assign lt = $signed(a) < $signed(b);

endmodule

`default_nettype wire
